>>> hdl/ipc_pkg.sv
// shared types and constants of the ingress packet classifier
package ipc_pkg;

    localparam logic [15:0] ETYPE_IPV4         = 16'h0800;
    localparam logic [15:0] ETYPE_ARP          = 16'h0806;
    localparam logic [15:0] HTYPE_ETHERNET     = 16'd1;
    localparam logic [15:0] ARP_OPER_REQ       = 16'd1;
    localparam logic [15:0] ARP_OPER_RSP       = 16'd2;
    localparam logic [7:0]  ICMP_TYPE_ECHO_REQ = 8'd8;
    localparam logic [7:0]  PROTO_NUM_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_NUM_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_NUM_UDP      = 8'd17;

    localparam int          CAPTURE_LEN   = 42;
    localparam logic [5:0]  POS_MAX       = 6'd63;

    typedef enum logic [1:0] {
        MODE_FRAME  = 2'd0,
        MODE_ARP_WR = 2'd1,
        MODE_FLT_WR = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VERDICT_DROP     = 2'd0,
        VERDICT_TX       = 2'd1,
        VERDICT_REDIRECT = 2'd2,
        VERDICT_RSVD     = 2'd3
    } verdict_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  redirect_queue;
        logic [47:0] reply_eth_dst;
        logic [47:0] reply_hw_addr;
        logic [47:0] reply_target_hw;
        logic [31:0] reply_sender_ip;
        logic [31:0] reply_target_ip;
    } result_t;

    typedef struct packed {
        logic        arp_we;
        logic        flt_we;
        logic [3:0]  index;
        logic [31:0] key;
        logic [47:0] mac;
        logic        valid;
    } tbl_wr_t;

    typedef struct packed {
        logic        arp_hit;
        logic [47:0] arp_mac;
        logic        flt_hit;
    } tbl_match_t;

endpackage

>>> hdl/ingress_packet_classifier_core.sv
// top level of the ingress packet classifier
//   channel | dir | handshake           | content
//   s_      | in  | s_tvalid / s_tready | frame byte or table write
//   m_      | out | m_tvalid / m_tready | one verdict per frame
//   cfg_    | in  | cfg_we              | socket_present_mask
// one beat per cycle while s_tready is high; the verdict is registered in the queue
// the tables are matched in the same cycle as the last beat
// a two-entry queue holds results; s_tready drops only when it is full
// reset clears position, frame queue, valid bits and the queue
module ingress_packet_classifier_core #(
    parameter int ARP_ENTRIES    = 16,
    parameter int FILTER_ENTRIES = 16,
    parameter int SOCKET_QUEUES  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // frame_byte, queue_index, entry_index, entry_key,
                                   // entry_mac, entry_valid
    input  logic [1:0]   s_tuser,  // mode
    input  logic         s_tlast,  // frame_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata,  // redirect_queue, reply_eth_dst, reply_hw_addr,
                                   // reply_target_hw, reply_sender_ip, reply_target_ip
    output logic [1:0]   m_tuser,  // verdict
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    logic                 acc;
    logic [7:0]           mask_reg;
    ipc_pkg::mode_t       mode;
    ipc_pkg::tbl_wr_t     wr;
    ipc_pkg::tbl_match_t  match;
    ipc_pkg::result_t     res;
    ipc_pkg::result_t     out;
    logic [31:0]          arp_key;
    logic [31:0]          flt_key;
    logic                 push;

    assign acc  = s_tvalid && s_tready;
    assign mode = ipc_pkg::mode_t'(s_tuser);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // table write decode
    assign wr.arp_we = acc && mode == ipc_pkg::MODE_ARP_WR;
    assign wr.flt_we = acc && mode == ipc_pkg::MODE_FLT_WR;
    assign wr.index  = s_tdata[19:16];
    assign wr.key    = s_tdata[51:20];
    assign wr.mac    = s_tdata[99:52];
    assign wr.valid  = s_tdata[100];

    ipc_tables #(
        .ARP_ENTRIES    (ARP_ENTRIES),
        .FILTER_ENTRIES (FILTER_ENTRIES)
    ) u_tables (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .arp_key (arp_key),
        .flt_key (flt_key),
        .match   (match)
    );

    ipc_front #(
        .SOCKET_QUEUES (SOCKET_QUEUES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (acc && mode == ipc_pkg::MODE_FRAME),
        .frame_byte  (s_tdata[7:0]),
        .frame_last  (s_tlast),
        .queue_index (s_tdata[15:8]),
        .socket_mask (mask_reg),
        .match       (match),
        .arp_key     (arp_key),
        .flt_key     (flt_key),
        .push        (push),
        .result      (res)
    );

    ipc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .not_full  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out)
    );

    // output packing
    assign m_tuser = out.verdict;
    assign m_tdata = {out.reply_target_ip, out.reply_sender_ip, out.reply_target_hw,
                      out.reply_hw_addr, out.reply_eth_dst, out.redirect_queue};

    a_no_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != ipc_pkg::VERDICT_RSVD)
        else $error("reserved verdict");

    a_queue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ipc_pkg::VERDICT_REDIRECT) |-> m_tdata[7:0] == 8'd0)
        else $error("queue set without redirect");

    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("stalled with nothing to send");

endmodule

>>> hdl/ipc_tables.sv
// arp and filter tables with parallel key match
module ipc_tables #(
    parameter int ARP_ENTRIES    = 16,
    parameter int FILTER_ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipc_pkg::tbl_wr_t     wr,
    input  logic [31:0]          arp_key,
    input  logic [31:0]          flt_key,
    output ipc_pkg::tbl_match_t  match
);

    localparam int AW = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int FW = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;

    logic [31:0] arp_key_reg [ARP_ENTRIES];
    logic [47:0] arp_mac_reg [ARP_ENTRIES];
    logic [ARP_ENTRIES-1:0] arp_valid_reg;
    logic [31:0] flt_key_reg [FILTER_ENTRIES];
    logic [FILTER_ENTRIES-1:0] flt_valid_reg;

    logic [AW-1:0] arp_slot;
    logic [FW-1:0] flt_slot;
    logic          arp_in_range;
    logic          flt_in_range;

    assign arp_slot     = AW'(32'(wr.index));
    assign flt_slot     = FW'(32'(wr.index));
    assign arp_in_range = 32'(wr.index) < ARP_ENTRIES;
    assign flt_in_range = 32'(wr.index) < FILTER_ENTRIES;

    // table payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr.arp_we && arp_in_range)
        begin
            arp_key_reg[arp_slot] <= wr.key;
            arp_mac_reg[arp_slot] <= wr.mac;
        end
        if (wr.flt_we && flt_in_range)
        begin
            flt_key_reg[flt_slot] <= wr.key;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arp_valid_reg <= '0;
            flt_valid_reg <= '0;
        end
        else
        begin
            if (wr.arp_we && arp_in_range)
            begin
                arp_valid_reg[arp_slot] <= wr.valid;
            end
            if (wr.flt_we && flt_in_range)
            begin
                flt_valid_reg[flt_slot] <= wr.valid;
            end
        end
    end

    // match, lowest slot wins
    always_comb
    begin
        match = '0;
        for (int i = ARP_ENTRIES - 1; i >= 0; i--)
        begin
            if (arp_valid_reg[i] && arp_key_reg[i] == arp_key)
            begin
                match.arp_hit = 1'b1;
                match.arp_mac = arp_mac_reg[i];
            end
        end
        for (int j = 0; j < FILTER_ENTRIES; j++)
        begin
            if (flt_valid_reg[j] && flt_key_reg[j] == flt_key)
            begin
                match.flt_hit = 1'b1;
            end
        end
    end

endmodule

>>> hdl/ipc_front.sv
// header capture and frame classification on the last beat
module ipc_front #(
    parameter int SOCKET_QUEUES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_last,
    input  logic [7:0]           queue_index,
    input  logic [7:0]           socket_mask,
    input  ipc_pkg::tbl_match_t  match,
    output logic [31:0]          arp_key,
    output logic [31:0]          flt_key,
    output logic                 push,
    output ipc_pkg::result_t     result
);

    logic [7:0] cap_reg [ipc_pkg::CAPTURE_LEN];
    logic [5:0] pos_reg;
    logic [5:0] pos_next;
    logic [7:0] fq_reg;
    logic [7:0] fq_now;
    logic [7:0] v [ipc_pkg::CAPTURE_LEN];
    logic [5:0] len;
    logic [15:0] ethertype;
    logic [7:0] proto;
    logic       sock;

    // header bytes, no reset
    always_ff @(posedge clk)
    begin
        if (beat && 32'(pos_reg) < ipc_pkg::CAPTURE_LEN)
        begin
            cap_reg[pos_reg] <= frame_byte;
        end
    end

    // position and frame queue
    always_comb
    begin
        if (frame_last)
        begin
            pos_next = '0;
        end
        else if (pos_reg < ipc_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 6'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fq_reg  <= '0;
        end
        else if (beat)
        begin
            pos_reg <= pos_next;
            fq_reg  <= fq_now;
        end
    end

    // header view with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < ipc_pkg::CAPTURE_LEN; i++)
        begin
            v[i] = (32'(pos_reg) == i) ? frame_byte : cap_reg[i];
        end
    end

    assign fq_now    = (pos_reg == '0) ? queue_index : fq_reg;
    assign len       = (pos_reg == ipc_pkg::POS_MAX) ? pos_reg : pos_reg + 6'd1;
    assign ethertype = {v[12], v[13]};
    assign proto     = v[23];
    assign arp_key   = {v[41], v[40], v[39], v[38]};
    assign flt_key   = {v[37], v[36], 8'h00, proto};
    assign sock      = 32'(fq_now) < SOCKET_QUEUES && fq_now < 8'd8 && socket_mask[fq_now[2:0]];
    assign push      = beat && frame_last;

    // verdict
    always_comb
    begin
        result = '0;
        if (len >= 6'd14)
        begin
            if (ethertype == ipc_pkg::ETYPE_ARP)
            begin
                if (len >= 6'd42 && {v[14], v[15]} == ipc_pkg::HTYPE_ETHERNET
                    && {v[16], v[17]} == ipc_pkg::ETYPE_IPV4 && v[18] == 8'd6
                    && v[19] == 8'd4 && {v[20], v[21]} == ipc_pkg::ARP_OPER_REQ
                    && match.arp_hit)
                begin
                    result.verdict         = ipc_pkg::VERDICT_TX;
                    result.reply_eth_dst   = {v[6], v[7], v[8], v[9], v[10], v[11]};
                    result.reply_hw_addr   = match.arp_mac;
                    result.reply_target_hw = {v[22], v[23], v[24], v[25], v[26], v[27]};
                    result.reply_sender_ip = arp_key;
                    result.reply_target_ip = {v[31], v[30], v[29], v[28]};
                end
            end
            else if (ethertype == ipc_pkg::ETYPE_IPV4 && len >= 6'd34 && v[14][3:0] == 4'd5)
            begin
                if (proto == ipc_pkg::PROTO_NUM_ICMP)
                begin
                    if (len >= 6'd42 && v[34] == ipc_pkg::ICMP_TYPE_ECHO_REQ)
                    begin
                        if (sock)
                        begin
                            result.verdict        = ipc_pkg::VERDICT_REDIRECT;
                            result.redirect_queue = fq_now;
                        end
                        else
                        begin
                            result.verdict = ipc_pkg::VERDICT_TX;
                        end
                    end
                end
                else if ((proto == ipc_pkg::PROTO_NUM_TCP || proto == ipc_pkg::PROTO_NUM_UDP)
                         && len >= 6'd38 && match.flt_hit && sock)
                begin
                    result.verdict        = ipc_pkg::VERDICT_REDIRECT;
                    result.redirect_queue = fq_now;
                end
            end
        end
    end

endmodule

>>> hdl/ipc_queue.sv
// two-entry result queue feeding the output side
module ipc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipc_pkg::result_t  push_data,
    output logic              not_full,
    output logic              out_valid,
    input  logic              out_ready,
    output ipc_pkg::result_t  out_data
);

    ipc_pkg::result_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign not_full  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg ^ push;
            rp_reg  <= rp_reg ^ pop;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");

endmodule
